// File: hw/rtl/circle_point_generator_assert.svh
// Assertion macros used by the circle point generator checker.
`ifndef CIRCLE_POINT_GENERATOR_ASSERT_SVH
`define CIRCLE_POINT_GENERATOR_ASSERT_SVH

// Checked at every clock edge outside reset.
`define CPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset cycles included.
`define CPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/cpg_pkg.sv
// Types and constants of the circle point generator.
package cpg_pkg;

  // Coordinate width of the center inputs.
  localparam int COORD_WIDTH = 12;
  localparam int PT_WIDTH    = COORD_WIDTH + 1;
  localparam int RAD_WIDTH   = COORD_WIDTH - 1;
  localparam int ERR_WIDTH   = 16;
  // Working width for the error update, with headroom for doubling.
  localparam int CALC_WIDTH  = ((ERR_WIDTH > COORD_WIDTH + 1) ? ERR_WIDTH : COORD_WIDTH + 1) + 3;

  // Eight mirrored points per step.
  localparam int PTS_PER_STEP = 8;
  localparam int IDX_WIDTH    = $clog2(PTS_PER_STEP);
  localparam logic [IDX_WIDTH-1:0] IDX_LAST = IDX_WIDTH'(PTS_PER_STEP - 1);

  // Request opcodes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [COORD_WIDTH-1:0] ucoord_t;
  typedef logic        [RAD_WIDTH-1:0]   radius_t;
  typedef logic signed [PT_WIDTH-1:0]    point_t;
  typedef logic signed [ERR_WIDTH-1:0]   err_t;
  typedef logic signed [CALC_WIDTH-1:0]  calc_t;
  typedef logic        [IDX_WIDTH-1:0]   idx_t;

  // One step's worth of data for the point sequencer.
  typedef struct packed {
    coord_t  cx;
    coord_t  cy;
    ucoord_t x;
    ucoord_t y;
    logic    fin;
  } burst_t;

  // Load request from the step unit to the point sequencer.
  typedef struct packed {
    logic   load;
    burst_t desc;
  } burst_req_t;

endpackage

// File: hw/rtl/cpg_if.sv
// Request and point channel interfaces of the circle point generator.
interface cpg_in_if import cpg_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    op;
  coord_t  center_x;
  coord_t  center_y;
  radius_t radius;

  modport source (output valid, op, center_x, center_y, radius, input ready);
  modport sink (input valid, op, center_x, center_y, radius, output ready);
endinterface

interface cpg_out_if import cpg_pkg::*; ();
  logic   valid;
  logic   ready;
  point_t point_x;
  point_t point_y;
  logic   last;

  modport source (output valid, point_x, point_y, last, input ready);
  modport sink (input valid, point_x, point_y, last, output ready);
endinterface

// File: hw/rtl/cpg_step.sv
// Circle state registers and the per-step error update.
module cpg_step import cpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  cpg_in_if.sink     req,
  input  logic       burst_ready,
  output burst_req_t burst
);

  coord_t  center_x_reg;
  coord_t  center_y_reg;
  ucoord_t step_x;
  ucoord_t step_y;
  err_t    error_term;
  logic    active;

  calc_t d_c, x_c, y_c, e_c, nx_c, ny_c, nd_c, err_start;
  logic  fin;
  logic  accept;

  assign req.ready = burst_ready;
  assign accept    = req.valid && req.ready;

  // Midpoint error update for the current step.
  always_comb begin
    d_c  = calc_t'(error_term);
    x_c  = calc_t'(step_x);
    y_c  = calc_t'(step_y);
    e_c  = ((d_c + y_c) <<< 1) - calc_t'(1);
    nx_c = x_c;
    ny_c = y_c;
    if (d_c < 0 && e_c <= 0) begin
      nx_c = x_c + calc_t'(1);
      nd_c = d_c + (nx_c <<< 1) + calc_t'(1);
    end else if (d_c > 0 && e_c > 0) begin
      ny_c = y_c - calc_t'(1);
      nd_c = d_c - ((ny_c <<< 1) + calc_t'(1));
    end else begin
      nx_c = x_c + calc_t'(1);
      ny_c = y_c - calc_t'(1);
      nd_c = d_c + ((nx_c - ny_c) <<< 1);
    end
    fin       = ny_c < nx_c;
    err_start = calc_t'(1) - (calc_t'(req.radius) <<< 1);
  end

  // Hand the pre-update position to the sequencer on an active step.
  always_comb begin
    burst.load    = accept && (req.op == OP_STEP) && active;
    burst.desc.cx = center_x_reg;
    burst.desc.cy = center_y_reg;
    burst.desc.x  = step_x;
    burst.desc.y  = step_y;
    burst.desc.fin = fin;
  end

  // Circle state: loaded on start, advanced on each active step.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x_reg <= '0;
      center_y_reg <= '0;
      step_x       <= '0;
      step_y       <= '0;
      error_term   <= '0;
      active       <= 1'b0;
    end else if (accept) begin
      if (req.op == OP_START) begin
        center_x_reg <= req.center_x;
        center_y_reg <= req.center_y;
        step_x       <= '0;
        step_y       <= ucoord_t'(req.radius);
        error_term   <= err_t'(err_start[ERR_WIDTH-1:0]);
        active       <= 1'b1;
      end else if (active) begin
        step_x     <= nx_c[COORD_WIDTH-1:0];
        step_y     <= ny_c[COORD_WIDTH-1:0];
        error_term <= err_t'(nd_c[ERR_WIDTH-1:0]);
        if (fin) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// File: hw/rtl/cpg_burst.sv
// Point sequencer: walks the eight mirrored points into the output register.
module cpg_burst import cpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  burst_req_t burst,
  output logic       burst_ready,
  cpg_out_if.source  pts
);

  burst_t desc;
  logic   busy;
  idx_t   idx;
  logic   out_valid;
  point_t out_x;
  point_t out_y;
  logic   out_last;

  logic    can_load;
  logic    emit;
  ucoord_t a_sel;
  ucoord_t b_sel;
  point_t  cx_w, cy_w, a_w, b_w, px, py;

  assign can_load    = !out_valid || pts.ready;
  assign emit        = busy && can_load;
  assign burst_ready = !busy || ((idx == IDX_LAST) && can_load);

  assign pts.valid   = out_valid;
  assign pts.point_x = out_x;
  assign pts.point_y = out_y;
  assign pts.last    = out_last;

  // Index bit 2 swaps x and y; bit 1 negates the x offset, bit 0 the y offset.
  always_comb begin
    a_sel = idx[2] ? desc.y : desc.x;
    b_sel = idx[2] ? desc.x : desc.y;
    cx_w  = point_t'(desc.cx);
    cy_w  = point_t'(desc.cy);
    a_w   = point_t'(a_sel);
    b_w   = point_t'(b_sel);
    px    = idx[1] ? (cx_w - a_w) : (cx_w + a_w);
    py    = idx[0] ? (cy_w - b_w) : (cy_w + b_w);
  end

  // Sequencer control and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (can_load) begin
        out_valid <= busy;
      end
      if (emit) begin
        idx <= idx + idx_t'(1);
        if (idx == IDX_LAST) begin
          busy <= 1'b0;
        end
      end
      if (burst.load) begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (burst.load) begin
      desc <= burst.desc;
    end
    if (emit) begin
      out_x    <= px;
      out_y    <= py;
      out_last <= desc.fin && (idx == IDX_LAST);
    end
  end

endmodule

// File: hw/rtl/circle_point_generator.sv
// An accepted step request loads its position into the point sequencer, which then
// registers the first point onto the output. A step gives eight points, one per cycle
// while the sink is ready; the next step is taken as the eighth point moves into the
// output register. Start requests and steps without an active circle give no points.
// Reset (rst, synchronous) drops any circle in progress and empties the output.
module circle_point_generator import cpg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cpg_in_if.sink    req,
  cpg_out_if.source pts
);

  burst_req_t burst;
  logic       burst_ready;

  // Circle state and error update.
  cpg_step u_step (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .burst_ready (burst_ready),
    .burst       (burst)
  );

  // Mirrored point sequencer and output register.
  cpg_burst u_burst (
    .clk         (clk),
    .rst         (rst),
    .burst       (burst),
    .burst_ready (burst_ready),
    .pts         (pts)
  );

endmodule

// File: hw/rtl/cpg_checker.sv
// Port-level checker for the circle point generator, bound to the top level.
`include "circle_point_generator_assert.svh"

module cpg_checker import cpg_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   req_ready,
  input logic   pts_valid,
  input logic   pts_ready,
  input point_t pts_x,
  input point_t pts_y,
  input logic   pts_last
);

  // A stalled point keeps its value.
  `CPG_ASSERT(a_pts_hold, pts_valid && !pts_ready |=> pts_valid && $stable(pts_x) && $stable(pts_y) && $stable(pts_last), "stalled point changed")

  // Reset empties the output register.
  `CPG_ASSERT_ALWAYS(a_rst_empty, rst |=> !pts_valid, "point valid right after reset")

  // After reset the sequencer is idle and takes a request at once.
  `CPG_ASSERT_ALWAYS(a_rst_ready, rst |=> req_ready, "request not ready after reset")

endmodule

bind circle_point_generator cpg_checker u_cpg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .pts_valid (pts.valid),
  .pts_ready (pts.ready),
  .pts_x     (pts.point_x),
  .pts_y     (pts.point_y),
  .pts_last  (pts.last)
);
